// File: src/cartridge_bank_mapper_irq_macros.svh
// assertion helpers used by the mapper top file
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH

// plain check on every clock, held off during reset
`define CBMI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication check on every clock, held off during reset
`define CBMI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/cbmi_pkg.sv
`timescale 1ns / 1ps

package cbmi_pkg;

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_CPU_RD = 3'd1,
    FUNC_CPU_WR = 3'd2,
    FUNC_VID_RD = 3'd3,
    FUNC_VID_WR = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    TGT_NONE     = 3'd0,
    TGT_PRG_ROM  = 3'd1,
    TGT_CHR_ROM  = 3'd2,
    TGT_CHR_RAM  = 3'd3,
    TGT_NT_RAM   = 3'd4,
    TGT_OPEN_BUS = 3'd5
  } target_e;

  // character memory fitted, any other code means none
  localparam logic [1:0] CHR_RO = 2'd1;
  localparam logic [1:0] CHR_RW = 2'd2;
  localparam logic [1:0] ChrKindReset = CHR_RO;

  localparam logic [1:0] MIR_A10   = 2'd0;
  localparam logic [1:0] MIR_A11   = 2'd1;
  localparam logic [1:0] MIR_PAGE0 = 2'd2;
  localparam logic [1:0] MIR_PAGE1 = 2'd3;

  localparam logic [3:0] REG_PRG_BANK  = 4'h8;
  localparam logic [3:0] REG_MIRROR    = 4'h9;
  localparam logic [3:0] REG_IRQ_CTRL  = 4'ha;
  localparam logic [3:0] REG_RELOAD_LO = 4'hb;
  localparam logic [3:0] REG_RELOAD_HI = 4'hc;
  localparam logic [3:0] REG_EEPROM    = 4'hd;

  localparam logic [3:0] LAST_PRG_BANK = 4'hf;

  typedef struct packed {
    func_e       func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  bus_data;
    logic        eeprom_bit;
  } item_t;

  typedef struct packed {
    logic [7:0][7:0] char_banks;
    logic [3:0]      prog_bank;
    logic [1:0]      mirror_mode;
    logic [1:0]      char_kind;
    logic            irq_next;
  } state_t;

  typedef struct packed {
    target_e     target;
    logic [17:0] mem_address;
    logic        mem_write;
    logic [7:0]  pass_data;
    logic        irq_out;
    logic        eeprom_strobe;
    logic        eeprom_clock;
    logic        eeprom_data;
  } result_t;

endpackage

// File: src/cartridge_bank_mapper_irq.sv
`timescale 1ns / 1ps
// channel   | dir | tdata (low bit up)                                  | tuser
// ----------+-----+-----------------------------------------------------+-------
// s_axis    | in  | address, write_data, bus_data, eeprom_bit, pad     | func
// m_axis    | out | mem_address, mem_write, pass_data, irq_out,         | target
//           |     | eeprom_strobe, eeprom_clock, eeprom_data, pad       |
// cfg       | in  | char_memory_kind, written when cfg_we_i is high     | -
//
// one item per cycle sustained while m_axis_tready is high; an accepted item
// passes through the input register, then the result register, with
// translation and register update in the single stage between them.
// rst_ni clears the bank, mirror and counter registers and both valid flags.
// while a result stalls the input register takes at most one more item, then
// s_axis_tready stays low until the result is taken.

`include "cartridge_bank_mapper_irq_macros.svh"

module cartridge_bank_mapper_irq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address[15:0], write_data[23:16], bus_data[31:24], eeprom_bit[32], zero pad
  input  logic [39:0] s_axis_tdata,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mem_address[17:0], mem_write[18], pass_data[26:19], irq_out[27],
  // eeprom_strobe[28], eeprom_clock[29], eeprom_data[30], zero pad
  output logic [31:0] m_axis_tdata,
  // target[2:0]
  output logic [2:0]  m_axis_tuser
);

  logic              in_valid_q, in_valid_d;
  cbmi_pkg::item_t   item_q;
  logic              out_valid_q, out_valid_d;
  cbmi_pkg::result_t res_q;
  cbmi_pkg::result_t res_d;
  cbmi_pkg::state_t  state;
  logic              advance;
  logic              in_load;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_load || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      item_q.func       <= cbmi_pkg::func_e'(s_axis_tuser);
      item_q.address    <= s_axis_tdata[15:0];
      item_q.write_data <= s_axis_tdata[23:16];
      item_q.bus_data   <= s_axis_tdata[31:24];
      item_q.eeprom_bit <= s_axis_tdata[32];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  cbmi_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (advance),
    .item_i      (item_q),
    .state_o     (state)
  );

  cbmi_xlate u_xlate (
    .item_i   (item_q),
    .state_i  (state),
    .result_o (res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.target;
  assign m_axis_tdata  = {1'b0, res_q.eeprom_data, res_q.eeprom_clock, res_q.eeprom_strobe,
                          res_q.irq_out, res_q.pass_data, res_q.mem_write,
                          res_q.mem_address};

  `CBMI_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
                   "input stalled with empty output")
  `CBMI_ASSERT_IMP(a_eeprom_quiet, m_axis_tvalid && !res_q.eeprom_strobe,
                   !res_q.eeprom_clock && !res_q.eeprom_data,
                   "eeprom pins driven without strobe")
  `CBMI_ASSERT_IMP(a_no_addr_unmapped,
                   m_axis_tvalid && (res_q.target == cbmi_pkg::TGT_NONE ||
                                     res_q.target == cbmi_pkg::TGT_OPEN_BUS),
                   res_q.mem_address == '0 && !res_q.mem_write,
                   "address on unmapped result")
  `CBMI_ASSERT_IMP(a_pass_only_open,
                   m_axis_tvalid && res_q.target != cbmi_pkg::TGT_OPEN_BUS,
                   res_q.pass_data == '0, "pass data outside open bus")

endmodule

// File: src/cbmi_regs.sv
`timescale 1ns / 1ps

module cbmi_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               fire_i,
  input  cbmi_pkg::item_t    item_i,
  output cbmi_pkg::state_t   state_o
);

  logic [7:0][7:0] banks_q, banks_d;
  logic [3:0]      prg_q, prg_d;
  logic [1:0]      mirror_q, mirror_d;
  logic [1:0]      kind_q;
  logic            en_q, en_d;
  logic [15:0]     cnt_q, cnt_d;
  logic [15:0]     reload_q, reload_d;
  logic            irq_q, irq_d;
  logic            reg_wr;
  logic [3:0]      sel;

  // register window is 0x6000 and up
  assign reg_wr = (item_i.func == cbmi_pkg::FUNC_CPU_WR) &&
                  (item_i.address[15] || (item_i.address[14] && item_i.address[13]));
  assign sel    = item_i.address[3:0];

  always_comb begin
    banks_d  = banks_q;
    prg_d    = prg_q;
    mirror_d = mirror_q;
    en_d     = en_q;
    cnt_d    = cnt_q;
    reload_d = reload_q;
    irq_d    = irq_q;
    if (fire_i) begin
      if (item_i.func == cbmi_pkg::FUNC_TICK && en_q) begin
        cnt_d = cnt_q - 16'd1;
        // wrap below zero
        if (cnt_q == 16'd0) begin
          irq_d = 1'b1;
          en_d  = 1'b0;
        end
      end
      if (reg_wr) begin
        if (!sel[3]) begin
          banks_d[sel[2:0]] = item_i.write_data;
        end else begin
          unique case (sel)
            cbmi_pkg::REG_PRG_BANK:  prg_d = item_i.write_data[3:0];
            cbmi_pkg::REG_MIRROR:    mirror_d = item_i.write_data[1:0];
            cbmi_pkg::REG_IRQ_CTRL: begin
              irq_d = 1'b0;
              en_d  = item_i.write_data[0];
              cnt_d = reload_q;
            end
            cbmi_pkg::REG_RELOAD_LO: reload_d[7:0] = item_i.write_data;
            cbmi_pkg::REG_RELOAD_HI: reload_d[15:8] = item_i.write_data;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banks_q  <= '0;
      prg_q    <= '0;
      mirror_q <= '0;
      kind_q   <= cbmi_pkg::ChrKindReset;
      en_q     <= 1'b0;
      cnt_q    <= '0;
      reload_q <= '0;
      irq_q    <= 1'b0;
    end else begin
      banks_q  <= banks_d;
      prg_q    <= prg_d;
      mirror_q <= mirror_d;
      en_q     <= en_d;
      cnt_q    <= cnt_d;
      reload_q <= reload_d;
      irq_q    <= irq_d;
      if (cfg_we_i) begin
        kind_q <= cfg_wdata_i;
      end
    end
  end

  assign state_o.char_banks  = banks_q;
  assign state_o.prog_bank   = prg_q;
  assign state_o.mirror_mode = mirror_q;
  assign state_o.char_kind   = kind_q;
  assign state_o.irq_next    = irq_d;

endmodule

// File: src/cbmi_xlate.sv
`timescale 1ns / 1ps

module cbmi_xlate (
  input  cbmi_pkg::item_t   item_i,
  input  cbmi_pkg::state_t  state_i,
  output cbmi_pkg::result_t result_o
);

  logic [13:0] va;
  logic        page;
  logic [17:0] nt_addr;
  logic [17:0] chr_addr;
  logic [3:0]  bank;
  logic        reg_wr;

  assign va = item_i.address[13:0];

  always_comb begin
    unique case (state_i.mirror_mode)
      cbmi_pkg::MIR_A10:   page = va[10];
      cbmi_pkg::MIR_A11:   page = va[11];
      cbmi_pkg::MIR_PAGE0: page = 1'b0;
      cbmi_pkg::MIR_PAGE1: page = 1'b1;
      default:             page = 1'b0;
    endcase
  end

  assign nt_addr  = {7'd0, page, va[9:0]};
  assign chr_addr = {state_i.char_banks[va[12:10]], va[9:0]};
  assign bank     = item_i.address[14] ? cbmi_pkg::LAST_PRG_BANK : state_i.prog_bank;
  assign reg_wr   = item_i.address[15] || (item_i.address[14] && item_i.address[13]);

  always_comb begin
    result_o             = '0;
    result_o.target      = cbmi_pkg::TGT_NONE;
    result_o.irq_out     = state_i.irq_next;
    unique case (item_i.func)
      cbmi_pkg::FUNC_CPU_RD: begin
        if (item_i.address[15:13] == 3'b011) begin
          // eeprom data shows on bit 4 in the work ram window
          result_o.target    = cbmi_pkg::TGT_OPEN_BUS;
          result_o.pass_data = {item_i.bus_data[7:5], item_i.eeprom_bit,
                                item_i.bus_data[3:0]};
        end else if (item_i.address[15]) begin
          result_o.target      = cbmi_pkg::TGT_PRG_ROM;
          result_o.mem_address = {bank, item_i.address[13:0]};
        end else begin
          result_o.target    = cbmi_pkg::TGT_OPEN_BUS;
          result_o.pass_data = item_i.bus_data;
        end
      end
      cbmi_pkg::FUNC_CPU_WR: begin
        if (reg_wr && item_i.address[3:0] == cbmi_pkg::REG_EEPROM) begin
          result_o.eeprom_strobe = 1'b1;
          result_o.eeprom_clock  = item_i.write_data[5];
          result_o.eeprom_data   = item_i.write_data[6];
        end
      end
      cbmi_pkg::FUNC_VID_RD: begin
        if (va[13]) begin
          result_o.target      = cbmi_pkg::TGT_NT_RAM;
          result_o.mem_address = nt_addr;
        end else if (state_i.char_kind == cbmi_pkg::CHR_RO) begin
          result_o.target      = cbmi_pkg::TGT_CHR_ROM;
          result_o.mem_address = chr_addr;
        end else if (state_i.char_kind == cbmi_pkg::CHR_RW) begin
          result_o.target      = cbmi_pkg::TGT_CHR_RAM;
          result_o.mem_address = chr_addr;
        end
      end
      cbmi_pkg::FUNC_VID_WR: begin
        if (va[13]) begin
          result_o.target      = cbmi_pkg::TGT_NT_RAM;
          result_o.mem_address = nt_addr;
          result_o.mem_write   = 1'b1;
        end else if (state_i.char_kind == cbmi_pkg::CHR_RW) begin
          result_o.target      = cbmi_pkg::TGT_CHR_RAM;
          result_o.mem_address = chr_addr;
          result_o.mem_write   = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
